// ===== hdl/snfw_pkg.sv =====
package snfw_pkg;

   localparam int CSR_IW = 3;
   localparam logic [CSR_IW-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_CENTER_Z = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_GRAV_MASS = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_SOFT_LENGTH = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_SCALE_RADIUS = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_MASS_RATIO = 3'd6;

   localparam int IN_W = 96;
   localparam int OUT_W = 104;

   // pipeline stage numbers
   localparam int ST_D = 1;
   localparam int ST_SQ = 2;
   localparam int ST_NRM = 3;
   localparam int ST_S1 = 4;
   localparam int ST_S2 = 5;
   localparam int ST_R0 = 6;
   localparam int ST_R1 = 7;
   localparam int ST_RQ = 40;
   localparam int ST_U0 = 41;
   localparam int ST_UQ = 74;
   localparam int ST_W = 75;
   localparam int ST_T0 = 76;
   localparam int ST_T = 109;
   localparam int ST_P1 = 110;
   localparam int ST_P2 = 111;
   localparam int ST_DEN = 112;
   localparam int ST_H0 = 113;
   localparam int ST_H = 146;
   localparam int ST_WH = 147;
   localparam int ST_F0 = 148;
   localparam int ST_F = 181;
   localparam int ST_G = 182;
   localparam int ST_V = 183;
   localparam int ST_OUT = 184;
   localparam int DIV_STEPS = 32;
   localparam int SQRT_STEPS = 32;

   typedef logic signed [11:0] exp_type;

   typedef struct packed {
      logic [31:0] m;
      exp_type     e;
   } pf_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [32:0] quo;
      logic [31:0] dvs;
      exp_type     e;
      logic        zero;
   } div_type;

   typedef struct packed {
      logic [35:0] rem;
      logic [31:0] root;
      logic [63:0] rad;
      exp_type     e;
      logic        zero;
   } sqrt_type;

   typedef struct packed {
      logic [31:0] acc;
      logic        clip;
   } fin_type;

   localparam pf_type PF_ONE = '{m: 32'h8000_0000, e: -12'sd31};

   function automatic pf_type pf_norm64(input logic [63:0] v, input exp_type e);
      pf_type      r;
      logic [5:0]  p;
      logic [63:0] sh;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            p = 6'(i);
         end
      end
      sh = v << (6'd63 - p);
      if (v == '0) begin
         r = '0;
      end else begin
         r.m = sh[63:32];
         r.e = e + exp_type'({6'd0, p}) - 12'sd31;
      end
      return r;
   endfunction

   function automatic pf_type pf_norm32(input logic [31:0] v, input exp_type e);
      return pf_norm64({32'd0, v}, e);
   endfunction

   function automatic pf_type pf_mul(input pf_type a, input pf_type b);
      pf_type      r;
      logic [63:0] pr;
      pr = {32'd0, a.m} * {32'd0, b.m};
      if (a.m == '0 || b.m == '0) begin
         r = '0;
      end else if (pr[63]) begin
         r.m = pr[63:32];
         r.e = a.e + b.e + 12'sd32;
      end else begin
         r.m = pr[62:31];
         r.e = a.e + b.e + 12'sd31;
      end
      return r;
   endfunction

   function automatic pf_type pf_add(input pf_type a, input pf_type b);
      pf_type      r;
      pf_type      x;
      pf_type      y;
      logic [12:0] diff;
      logic [31:0] bm;
      logic [32:0] sum;
      x = a;
      y = b;
      if (b.e > a.e) begin
         x = b;
         y = a;
      end
      diff = {x.e[11], x.e} - {y.e[11], y.e};
      bm = (diff >= 13'd32) ? 32'd0 : (y.m >> diff[4:0]);
      sum = {1'b0, x.m} + {1'b0, bm};
      if (a.m == '0) begin
         r = b;
      end else if (b.m == '0) begin
         r = a;
      end else if (sum[32]) begin
         r.m = sum[32:1];
         r.e = x.e + 12'sd1;
      end else begin
         r.m = sum[31:0];
         r.e = x.e;
      end
      return r;
   endfunction

   function automatic pf_type pf_twice(input pf_type a);
      pf_type r;
      r = a;
      if (a.m != '0) begin
         r.e = a.e + 12'sd1;
      end
      return r;
   endfunction

   function automatic div_type div_init(input pf_type a, input pf_type b);
      div_type d;
      d.dvs = b.m;
      d.zero = (a.m == '0) || (b.m == '0);
      d.e = a.e - 12'sd32 - b.e;
      if (a.m >= b.m) begin
         d.rem = a.m - b.m;
         d.quo = 33'd1;
      end else begin
         d.rem = a.m;
         d.quo = 33'd0;
      end
      return d;
   endfunction

   function automatic div_type div_step(input div_type d);
      div_type     r;
      logic [32:0] t;
      r = d;
      t = {d.rem, 1'b0};
      if (t >= {1'b0, d.dvs}) begin
         t = t - {1'b0, d.dvs};
         r.quo = {d.quo[31:0], 1'b1};
      end else begin
         r.quo = {d.quo[31:0], 1'b0};
      end
      r.rem = t[31:0];
      return r;
   endfunction

   function automatic pf_type div_fin(input div_type d);
      pf_type r;
      if (d.zero) begin
         r = '0;
      end else if (d.quo[32]) begin
         r.m = d.quo[32:1];
         r.e = d.e + 12'sd1;
      end else begin
         r.m = d.quo[31:0];
         r.e = d.e;
      end
      return r;
   endfunction

   function automatic sqrt_type sqrt_init(input pf_type a);
      sqrt_type s;
      exp_type  t;
      t = a.e - (a.e[0] ? 12'sd31 : 12'sd32);
      s.rem = '0;
      s.root = '0;
      s.rad = a.e[0] ? {1'b0, a.m, 31'd0} : {a.m, 32'd0};
      s.e = t >>> 1;
      s.zero = (a.m == '0);
      return s;
   endfunction

   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type    r;
      logic [35:0] r2;
      logic [35:0] tr;
      r = s;
      r2 = {s.rem[33:0], s.rad[63:62]};
      tr = {2'b00, s.root, 2'b01};
      if (r2 >= tr) begin
         r.rem = r2 - tr;
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem = r2;
         r.root = {s.root[30:0], 1'b0};
      end
      r.rad = {s.rad[61:0], 2'b00};
      return r;
   endfunction

   function automatic pf_type sqrt_fin(input sqrt_type s);
      pf_type r;
      if (s.zero) begin
         r = '0;
      end else begin
         r.m = s.root;
         r.e = s.e;
      end
      return r;
   endfunction

   function automatic fin_type finish(input pf_type v, input logic [32:0] d);
      fin_type     f;
      exp_type     sh;
      exp_type     nsh;
      logic [31:0] raw;
      logic [31:0] lim;
      logic        over;
      sh = v.e + 12'sd16;
      nsh = -sh;
      over = (v.m != '0) && (sh > 12'sd0);
      if (v.m == '0 || sh > 12'sd0 || sh <= -12'sd32) begin
         raw = '0;
      end else begin
         raw = v.m >> nsh[4:0];
      end
      lim = d[32] ? 32'h7FFF_FFFF : 32'h8000_0000;
      f.clip = 1'b0;
      if (over || raw > lim) begin
         raw = lim;
         f.clip = 1'b1;
      end
      f.acc = d[32] ? raw : (32'd0 - raw);
      if (d == '0) begin
         f = '0;
      end
      return f;
   endfunction

endpackage

// ===== hdl/snfw_halo_acceleration_top.sv =====
// super-nfw halo acceleration with plummer softening, fixed point q16.16
// req channel: one transaction carries a position (pos_x, pos_y, pos_z)
// rsp channel: one transaction per request, in order, with the three
//   saturated acceleration components and the clipped and at_center flags
// csr port: write-only, csr_index selects centre x/y/z, grav_mass,
//   soft_length, scale_radius, mass_ratio; it must be written only while
//   no transaction is in flight, which the block itself does not enforce
// throughput: one transaction per cycle, sustained while rsp_tready stays high
// the pipeline depth is set by three 32-step square-root units and four
//   33-step dividers, in five groups in series (some units side by side),
//   each retiring one bit per stage
// constants derived from the registers (scale radius, softening squared,
//   mass quotient) are recomputed continuously through their own registers
//   and settle well before any transaction reaches the stage that uses them
// reset clears the registers to their defaults and empties the pipeline
// when rsp_tready is low with a result waiting, the whole pipeline holds
//   and req_tready drops; nothing is lost or repeated
module snfw_halo_acceleration_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // pos_x, pos_y, pos_z
   input  logic [snfw_pkg::IN_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // acc_x, acc_y, acc_z, clipped, at_center, zero fill
   output logic [snfw_pkg::OUT_W-1:0]  rsp_tdata,
   input  logic                        csr_we,
   input  logic [snfw_pkg::CSR_IW-1:0] csr_index,
   input  logic [31:0]                 csr_wdata
);
   import snfw_pkg::*;

   typedef struct packed {
      logic [2:0][32:0] d;
      pf_type [2:0]     dn;
      logic [2:0][63:0] sqv;
      pf_type [2:0]     sq;
      pf_type           s;
      pf_type           sp;
      pf_type           q;
      pf_type           qs;
      pf_type           r;
      pf_type           u;
      pf_type           up;
      pf_type           w;
      pf_type           rr;
      pf_type           t;
      pf_type           tp1;
      pf_type           num;
      pf_type           tt;
      pf_type           ttt;
      pf_type           p2;
      pf_type           den;
      pf_type           h;
      pf_type           wh;
      pf_type           f;
      pf_type           g;
      pf_type [2:0]     v;
      div_type          da;
      div_type          db;
      sqrt_type         sa;
      sqrt_type         sb;
      logic [2:0][31:0] acc;
      logic             clip;
      logic             ctr;
   } slot_type;

   logic [31:0] center_x_ff;
   logic [31:0] center_y_ff;
   logic [31:0] center_z_ff;
   logic [31:0] grav_mass_ff;
   logic [31:0] soft_length_ff;
   logic [31:0] scale_radius_ff;
   logic [31:0] mass_ratio_ff;

   pf_type  rs_ff;
   pf_type  rs2_ff;
   pf_type  e2n_ff;
   pf_type  e2_ff;
   pf_type  gm_ff;
   pf_type  mp_ff;
   div_type cdiv_ff [DIV_STEPS+1];
   pf_type  c_ff;

   logic [ST_OUT:1] vld_ff;
   slot_type        slot_ff [1:ST_OUT];
   slot_type        slot_in [1:ST_OUT];
   logic            adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         grav_mass_ff <= '0;
         soft_length_ff <= '0;
         scale_radius_ff <= 32'h0001_0000;
         mass_ratio_ff <= 32'h8000_0000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_CENTER_Z: center_z_ff <= csr_wdata;
            CSR_GRAV_MASS: grav_mass_ff <= csr_wdata;
            CSR_SOFT_LENGTH: soft_length_ff <= csr_wdata;
            CSR_SCALE_RADIUS: scale_radius_ff <= csr_wdata;
            CSR_MASS_RATIO: mass_ratio_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // constants derived from the registers
   always_ff @(posedge clock) begin
      rs_ff <= pf_norm32((scale_radius_ff == '0) ? 32'd1 : scale_radius_ff, -12'sd16);
      rs2_ff <= pf_mul(rs_ff, rs_ff);
      e2n_ff <= pf_norm32(soft_length_ff, -12'sd16);
      e2_ff <= pf_mul(e2n_ff, e2n_ff);
      gm_ff <= pf_norm32(grav_mass_ff, -12'sd16);
      mp_ff <= pf_norm32((mass_ratio_ff == '0) ? 32'd1 : mass_ratio_ff, -12'sd31);
      cdiv_ff[0] <= div_init(gm_ff, mp_ff);
      for (int j = 1; j <= DIV_STEPS; j++) begin
         cdiv_ff[j] <= div_step(cdiv_ff[j-1]);
      end
      c_ff <= div_fin(cdiv_ff[DIV_STEPS]);
   end

   assign adv = ~vld_ff[ST_OUT] | rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ST_OUT-1:1], req_tvalid};
      end
   end

   for (genvar n = 1; n <= ST_OUT; n++) begin : g_stage
      if (n == ST_D) begin : g_first
         always_comb begin
            slot_in[n] = '0;
            slot_in[n].d[0] = {req_tdata[31], req_tdata[31:0]}
                              - {center_x_ff[31], center_x_ff};
            slot_in[n].d[1] = {req_tdata[63], req_tdata[63:32]}
                              - {center_y_ff[31], center_y_ff};
            slot_in[n].d[2] = {req_tdata[95], req_tdata[95:64]}
                              - {center_z_ff[31], center_z_ff};
         end
      end else begin : g_next
         always_comb begin
            logic [32:0] mag;
            fin_type     fo;
            slot_in[n] = slot_ff[n-1];
            if (n == ST_SQ) begin
               for (int i = 0; i < 3; i++) begin
                  mag = slot_ff[n-1].d[i][32] ? (33'd0 - slot_ff[n-1].d[i])
                                              : slot_ff[n-1].d[i];
                  slot_in[n].sqv[i] = {32'd0, mag[31:0]} * {32'd0, mag[31:0]};
                  slot_in[n].dn[i] = pf_norm32(mag[31:0], -12'sd16);
               end
            end
            if (n == ST_NRM) begin
               for (int i = 0; i < 3; i++) begin
                  slot_in[n].sq[i] = pf_norm64(slot_ff[n-1].sqv[i], -12'sd32);
               end
            end
            if (n == ST_S1) begin
               slot_in[n].s = pf_add(slot_ff[n-1].sq[0], slot_ff[n-1].sq[1]);
            end
            if (n == ST_S2) begin
               slot_in[n].s = pf_add(slot_ff[n-1].s, slot_ff[n-1].sq[2]);
            end
            if (n == ST_R0) begin
               slot_in[n].sp = pf_add(slot_ff[n-1].s, e2_ff);
               slot_in[n].sa = sqrt_init(slot_ff[n-1].s);
            end
            if (n >= ST_R1 && n < ST_R1 + SQRT_STEPS) begin
               slot_in[n].sa = sqrt_step(slot_ff[n-1].sa);
            end
            if (n == ST_R1) begin
               slot_in[n].da = div_init(slot_ff[n-1].s, slot_ff[n-1].sp);
            end
            if (n > ST_R1 && n <= ST_R1 + DIV_STEPS) begin
               slot_in[n].da = div_step(slot_ff[n-1].da);
            end
            if (n == ST_RQ) begin
               slot_in[n].r = sqrt_fin(slot_ff[n-1].sa);
               slot_in[n].q = div_fin(slot_ff[n-1].da);
            end
            if (n == ST_U0) begin
               slot_in[n].db = div_init(slot_ff[n-1].r, rs_ff);
               slot_in[n].sb = sqrt_init(slot_ff[n-1].q);
            end
            if (n > ST_U0 && n <= ST_U0 + DIV_STEPS) begin
               slot_in[n].db = div_step(slot_ff[n-1].db);
               slot_in[n].sb = sqrt_step(slot_ff[n-1].sb);
            end
            if (n == ST_UQ) begin
               slot_in[n].u = div_fin(slot_ff[n-1].db);
               slot_in[n].qs = sqrt_fin(slot_ff[n-1].sb);
            end
            if (n == ST_W) begin
               slot_in[n].up = pf_add(PF_ONE, slot_ff[n-1].u);
               slot_in[n].w = (soft_length_ff == '0) ? PF_ONE
                            : pf_mul(slot_ff[n-1].q, slot_ff[n-1].qs);
               slot_in[n].rr = pf_mul(rs2_ff, slot_ff[n-1].r);
            end
            if (n == ST_T0) begin
               slot_in[n].sa = sqrt_init(slot_ff[n-1].up);
            end
            if (n > ST_T0 && n <= ST_T0 + SQRT_STEPS) begin
               slot_in[n].sa = sqrt_step(slot_ff[n-1].sa);
            end
            if (n == ST_T) begin
               slot_in[n].t = sqrt_fin(slot_ff[n-1].sa);
            end
            if (n == ST_P1) begin
               slot_in[n].tp1 = pf_add(slot_ff[n-1].t, PF_ONE);
               slot_in[n].num = pf_add(pf_twice(slot_ff[n-1].t), PF_ONE);
               slot_in[n].tt = pf_mul(slot_ff[n-1].t, slot_ff[n-1].t);
            end
            if (n == ST_P2) begin
               slot_in[n].ttt = pf_mul(slot_ff[n-1].tt, slot_ff[n-1].t);
               slot_in[n].p2 = pf_mul(slot_ff[n-1].tp1, slot_ff[n-1].tp1);
            end
            if (n == ST_DEN) begin
               slot_in[n].den = pf_twice(pf_mul(slot_ff[n-1].ttt, slot_ff[n-1].p2));
            end
            if (n == ST_H0) begin
               slot_in[n].da = div_init(slot_ff[n-1].num, slot_ff[n-1].den);
            end
            if (n > ST_H0 && n <= ST_H0 + DIV_STEPS) begin
               slot_in[n].da = div_step(slot_ff[n-1].da);
            end
            if (n == ST_H) begin
               slot_in[n].h = div_fin(slot_ff[n-1].da);
            end
            if (n == ST_WH) begin
               slot_in[n].wh = pf_mul(slot_ff[n-1].w, slot_ff[n-1].h);
            end
            if (n == ST_F0) begin
               slot_in[n].da = div_init(slot_ff[n-1].wh, slot_ff[n-1].rr);
            end
            if (n > ST_F0 && n <= ST_F0 + DIV_STEPS) begin
               slot_in[n].da = div_step(slot_ff[n-1].da);
            end
            if (n == ST_F) begin
               slot_in[n].f = div_fin(slot_ff[n-1].da);
            end
            if (n == ST_G) begin
               slot_in[n].g = pf_mul(c_ff, slot_ff[n-1].f);
            end
            if (n == ST_V) begin
               for (int i = 0; i < 3; i++) begin
                  slot_in[n].v[i] = pf_mul(slot_ff[n-1].g, slot_ff[n-1].dn[i]);
               end
            end
            if (n == ST_OUT) begin
               slot_in[n].clip = 1'b0;
               for (int i = 0; i < 3; i++) begin
                  fo = finish(slot_ff[n-1].v[i], slot_ff[n-1].d[i]);
                  slot_in[n].acc[i] = fo.acc;
                  slot_in[n].clip = slot_in[n].clip | fo.clip;
               end
               slot_in[n].ctr = (slot_ff[n-1].s.m == '0) && (soft_length_ff == '0);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            slot_ff[n] <= slot_in[n];
         end
      end
   end

   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata = {6'd0, slot_ff[ST_OUT].ctr, slot_ff[ST_OUT].clip,
                       slot_ff[ST_OUT].acc[2], slot_ff[ST_OUT].acc[1],
                       slot_ff[ST_OUT].acc[0]};

endmodule
